@@ rtl/setsu_pkg.sv @@
// ----------------------------------------------------------------------------
// setsu_pkg: shared types and constants of the sparse eligibility trace store
// Command codes, configuration register indexes and the word formats.
// ----------------------------------------------------------------------------
package setsu_pkg;

	localparam int FEAT_W  = 12;
	localparam int TRACE_W = 16;
	localparam int WGT_W   = 32;
	localparam int QSUM_W  = 40;
	localparam int CNT_W   = 9;

	localparam logic [2:0] CMD_SET    = 3'd0;
	localparam logic [2:0] CMD_CLEAR  = 3'd1;
	localparam logic [2:0] CMD_DECAY  = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_ACCUM  = 3'd4;
	localparam logic [2:0] CMD_INIT   = 3'd5;

	localparam logic [1:0] CFG_STEP_SCALE = 2'd0;
	localparam logic [1:0] CFG_MIN_TRACE  = 2'd1;
	localparam logic [1:0] CFG_INIT_WGT   = 2'd2;

	localparam logic [15:0] STEP_SCALE_RST = 16'd256;
	localparam logic [15:0] MIN_TRACE_RST  = 16'd328;
	localparam logic [15:0] THR_MAX        = 16'hFFFF;

	typedef struct packed {
		logic [2:0]                cmd;
		logic [FEAT_W-1:0]         feature;
		logic [TRACE_W-1:0]        amount;
		logic signed [WGT_W-1:0]   delta;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic signed [QSUM_W-1:0]  q_sum;
		logic                      q_valid;
		logic [CNT_W-1:0]          active_count;
		logic [TRACE_W-1:0]        min_trace;
	} result_t;

endpackage

@@ rtl/sparse_eligibility_trace_store_unit.sv @@
// ----------------------------------------------------------------------------
// sparse_eligibility_trace_store_unit: sparse replacing eligibility traces
// Weight and trace tables with an active list of live traces, for linear
// Sarsa in fixed point (Q1.15 traces, Q16.16 weights).
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays high
// until its single result word has been shown on result for one cycle with
// done high, and the receiver must take it then, as it cannot stall the block.
// Timing is set by the single-port table memories, one access per cycle each:
// set and clear read the trace and index tables, accumulate_q reads the
// weight table, decay walks every live trace with a removal for each one that
// decays to zero or below the threshold, and update_weights walks every live
// trace (read, two multiply stages, write back). A set on a full list adds a
// cull walk over the live entries, plus a removal for each culled entry, for
// each threshold raise.
// After reset, and on every init command, a clearing pass writes all
// TABLE_DEPTH entries of the trace and weight tables, one per cycle, during
// which busy is high; configuration writes are taken at any time.
module sparse_eligibility_trace_store_unit #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_LIVE    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  setsu_pkg::item_t   item,
	output logic               done,
	output setsu_pkg::result_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(MAX_LIVE);
	localparam int CW = $clog2(MAX_LIVE + 1);
	localparam int FW = setsu_pkg::FEAT_W;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_SET_RD    = 5'd1;
	localparam logic [4:0] S_SET_FULL  = 5'd2;
	localparam logic [4:0] S_CLR_RD    = 5'd3;
	localparam logic [4:0] S_REM_A     = 5'd4;
	localparam logic [4:0] S_REM_B     = 5'd5;
	localparam logic [4:0] S_CULL_NEXT = 5'd6;
	localparam logic [4:0] S_CULL_AL   = 5'd7;
	localparam logic [4:0] S_CULL_TR   = 5'd8;
	localparam logic [4:0] S_DEC_NEXT  = 5'd9;
	localparam logic [4:0] S_DEC_AL    = 5'd10;
	localparam logic [4:0] S_DEC_TR    = 5'd11;
	localparam logic [4:0] S_UPD_NEXT  = 5'd12;
	localparam logic [4:0] S_UPD_AL    = 5'd13;
	localparam logic [4:0] S_UPD_TR    = 5'd14;
	localparam logic [4:0] S_UPD_MUL   = 5'd15;
	localparam logic [4:0] S_UPD_WR    = 5'd16;
	localparam logic [4:0] S_ACC_RD    = 5'd17;
	localparam logic [4:0] S_SWEEP     = 5'd18;
	localparam logic [4:0] S_DONE      = 5'd19;

	// Control and configuration registers.
	logic [4:0]         st_q, ret_q;
	logic [FW-1:0]      f_q, wf_q, rmf_q;
	logic [15:0]        amt_q;
	logic signed [31:0] delta_q;
	logic               last_q, inr_q;
	logic [CW-1:0]      live_q, loc_q;
	logic [LW-1:0]      rmloc_q;
	logic [15:0]        thr_q;
	logic signed [39:0] acc_q, qsum_q;
	logic               qv_q;
	logic [AW-1:0]      sw_q;
	logic signed [31:0] swval_q;
	logic               swinit_q;
	logic [15:0]        step_scale_q, min_trace_q;
	logic signed [31:0] init_wgt_q;

	// Trace table.
	logic [15:0]   tr_mem [TABLE_DEPTH];
	logic [15:0]   tr_rd, tr_wdata;
	logic [AW-1:0] tr_raddr, tr_waddr;
	logic          tr_re, tr_we;

	// Weight table.
	logic signed [31:0] wt_mem [TABLE_DEPTH];
	logic signed [31:0] wt_rd, wt_wdata;
	logic [AW-1:0]      wt_raddr, wt_waddr;
	logic               wt_re, wt_we;

	// Active list of live features.
	logic [FW-1:0] al_mem [MAX_LIVE];
	logic [FW-1:0] al_rd, al_wdata;
	logic [LW-1:0] al_raddr, al_waddr;
	logic          al_re, al_we;

	// Inverse index: feature to list position.
	logic [LW-1:0] iv_mem [TABLE_DEPTH];
	logic [LW-1:0] iv_rd, iv_wdata;
	logic [AW-1:0] iv_raddr, iv_waddr;
	logic          iv_re, iv_we;

	always_ff @(posedge clk) begin
		if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
		if (tr_re) tr_rd <= tr_mem[tr_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
		if (wt_re) wt_rd <= wt_mem[wt_raddr];
	end

	always_ff @(posedge clk) begin
		if (al_we) al_mem[al_waddr] <= al_wdata;
		if (al_re) al_rd <= al_mem[al_raddr];
	end

	always_ff @(posedge clk) begin
		if (iv_we) iv_mem[iv_waddr] <= iv_wdata;
		if (iv_re) iv_rd <= iv_mem[iv_raddr];
	end

	// Weight increment for update_weights; the walked trace is on tr_rd.
	logic signed [32:0] inc;

	setsu_incr u_incr (
		.clk   (clk),
		.delta (delta_q),
		.scale (step_scale_q),
		.trace (tr_rd),
		.inc   (inc)
	);

	// Datapath arithmetic.
	logic        in_range;
	logic [32:0] dec_prod;
	logic [16:0] dec_rnd;
	logic [15:0] dec_nt;
	logic [16:0] thr_p5;
	logic [32:0] div_prod;
	logic [17:0] raise_sum;
	logic [15:0] thr_raised;
	logic signed [33:0] wsum;
	logic signed [31:0] wsat;
	logic signed [40:0] asum;
	logic signed [39:0] asat;

	assign in_range = 32'(item.feature) < 32'(TABLE_DEPTH);

	always_comb begin
		// Decay: round(trace*rate/2^15), saturated to 16 bits.
		dec_prod = 33'(tr_rd) * 33'(amt_q) + 33'd16384;
		dec_rnd  = dec_prod[31:15];
		dec_nt   = dec_rnd[16] ? 16'hFFFF : dec_rnd[15:0];

		// Raise: round(thr*1.1) = thr + floor((thr+5)/10); the divide by ten is
		// a multiply by 52429/2^19, exact for these operand sizes.
		thr_p5    = 17'(thr_q) + 17'd5;
		div_prod  = 33'(thr_p5) * 33'd52429;
		raise_sum = 18'(thr_q) + 18'(div_prod[32:19]);
		if (raise_sum <= 18'(thr_q)) raise_sum = 18'(thr_q) + 18'd1;
		thr_raised = (raise_sum > 18'd65535) ? 16'hFFFF : raise_sum[15:0];

		// Weight update with 32-bit saturation.
		wsum = 34'(wt_rd) + 34'(inc);
		if (wsum > 34'sd2147483647)       wsat = 32'sh7FFFFFFF;
		else if (wsum < -34'sd2147483648) wsat = 32'sh80000000;
		else                              wsat = wsum[31:0];

		// Accumulation with 40-bit saturation; an out-of-range tile adds zero.
		asum = 41'(acc_q) + (inr_q ? 41'(wt_rd) : 41'sd0);
		if (asum > 41'sd549755813887)       asat = 40'sh7FFFFFFFFF;
		else if (asum < -41'sd549755813888) asat = 40'sh8000000000;
		else                                asat = asum[39:0];
	end

	// Memory port control, decoded from the current state.
	always_comb begin
		tr_re = 1'b0; tr_raddr = '0; tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0;
		wt_re = 1'b0; wt_raddr = '0; wt_we = 1'b0; wt_waddr = '0; wt_wdata = '0;
		al_re = 1'b0; al_raddr = '0; al_we = 1'b0; al_waddr = '0; al_wdata = '0;
		iv_re = 1'b0; iv_raddr = '0; iv_we = 1'b0; iv_waddr = '0; iv_wdata = '0;
		unique case (st_q)
			S_IDLE: begin
				tr_raddr = AW'(item.feature);
				iv_raddr = AW'(item.feature);
				wt_raddr = AW'(item.feature);
				if (start && in_range) begin
					if (item.cmd == setsu_pkg::CMD_SET || item.cmd == setsu_pkg::CMD_CLEAR) begin
						tr_re = 1'b1;
						iv_re = 1'b1;
					end
					if (item.cmd == setsu_pkg::CMD_ACCUM) wt_re = 1'b1;
				end
			end
			S_SET_RD: begin
				if (tr_rd != '0) begin
					tr_we    = 1'b1;
					tr_waddr = AW'(f_q);
					tr_wdata = amt_q;
				end
			end
			S_SET_FULL: begin
				if (32'(live_q) < 32'(MAX_LIVE)) begin
					tr_we    = 1'b1;
					tr_waddr = AW'(f_q);
					tr_wdata = amt_q;
					al_we    = 1'b1;
					al_waddr = LW'(live_q);
					al_wdata = f_q;
					iv_we    = 1'b1;
					iv_waddr = AW'(f_q);
					iv_wdata = LW'(live_q);
				end
			end
			S_REM_A: begin
				// Fetch the last entry, which fills the hole, and zero the trace.
				al_re    = 1'b1;
				al_raddr = LW'(live_q - CW'(1));
				tr_we    = 1'b1;
				tr_waddr = AW'(rmf_q);
				tr_wdata = '0;
			end
			S_REM_B: begin
				al_we    = 1'b1;
				al_waddr = rmloc_q;
				al_wdata = al_rd;
				iv_we    = 1'b1;
				iv_waddr = AW'(al_rd);
				iv_wdata = rmloc_q;
			end
			S_CULL_NEXT, S_DEC_NEXT: begin
				al_raddr = LW'(loc_q - CW'(1));
				al_re    = (loc_q != '0);
			end
			S_CULL_AL, S_DEC_AL: begin
				tr_re    = 1'b1;
				tr_raddr = AW'(al_rd);
			end
			S_DEC_TR: begin
				tr_we    = 1'b1;
				tr_waddr = AW'(wf_q);
				tr_wdata = dec_nt;
			end
			S_UPD_NEXT: begin
				al_raddr = LW'(loc_q);
				al_re    = (loc_q < live_q);
			end
			S_UPD_AL: begin
				tr_re    = 1'b1;
				tr_raddr = AW'(al_rd);
				wt_re    = 1'b1;
				wt_raddr = AW'(al_rd);
			end
			S_UPD_WR: begin
				wt_we    = 1'b1;
				wt_waddr = AW'(wf_q);
				wt_wdata = wsat;
			end
			S_SWEEP: begin
				tr_we    = 1'b1;
				tr_waddr = sw_q;
				tr_wdata = '0;
				wt_we    = 1'b1;
				wt_waddr = sw_q;
				wt_wdata = swval_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_SWEEP;
			ret_q        <= S_IDLE;
			f_q          <= '0;
			wf_q         <= '0;
			rmf_q        <= '0;
			amt_q        <= '0;
			delta_q      <= '0;
			last_q       <= 1'b0;
			inr_q        <= 1'b0;
			live_q       <= '0;
			loc_q        <= '0;
			rmloc_q      <= '0;
			thr_q        <= setsu_pkg::MIN_TRACE_RST;
			acc_q        <= '0;
			qsum_q       <= '0;
			qv_q         <= 1'b0;
			sw_q         <= '0;
			swval_q      <= '0;
			swinit_q     <= 1'b0;
			step_scale_q <= setsu_pkg::STEP_SCALE_RST;
			min_trace_q  <= setsu_pkg::MIN_TRACE_RST;
			init_wgt_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					setsu_pkg::CFG_STEP_SCALE: step_scale_q <= cfg_data[15:0];
					setsu_pkg::CFG_MIN_TRACE:  min_trace_q  <= cfg_data[15:0];
					setsu_pkg::CFG_INIT_WGT:   init_wgt_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						f_q     <= item.feature;
						amt_q   <= item.amount;
						delta_q <= item.delta;
						last_q  <= item.last;
						inr_q   <= in_range;
						qsum_q  <= '0;
						qv_q    <= 1'b0;
						case (item.cmd)
							setsu_pkg::CMD_SET: begin
								if (!in_range)            st_q <= S_DONE;
								else if (item.amount == '0) st_q <= S_CLR_RD;
								else                      st_q <= S_SET_RD;
							end
							setsu_pkg::CMD_CLEAR: st_q <= in_range ? S_CLR_RD : S_DONE;
							setsu_pkg::CMD_DECAY: begin
								loc_q <= live_q;
								st_q  <= S_DEC_NEXT;
							end
							setsu_pkg::CMD_UPDATE: begin
								loc_q <= '0;
								st_q  <= S_UPD_NEXT;
							end
							setsu_pkg::CMD_ACCUM: st_q <= S_ACC_RD;
							setsu_pkg::CMD_INIT: begin
								sw_q     <= '0;
								swval_q  <= init_wgt_q;
								swinit_q <= 1'b1;
								live_q   <= '0;
								thr_q    <= min_trace_q;
								acc_q    <= '0;
								st_q     <= S_SWEEP;
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_SET_RD: begin
					// A live trace is simply overwritten.
					st_q <= (tr_rd != '0) ? S_DONE : S_SET_FULL;
				end
				S_SET_FULL: begin
					if (32'(live_q) < 32'(MAX_LIVE)) begin
						live_q <= live_q + CW'(1);
						st_q   <= S_DONE;
					end else if (thr_q == setsu_pkg::THR_MAX) begin
						// Threshold saturated and list still full: drop the trace.
						st_q <= S_DONE;
					end else begin
						thr_q <= thr_raised;
						loc_q <= live_q;
						st_q  <= S_CULL_NEXT;
					end
				end
				S_CLR_RD: begin
					if (tr_rd != '0 && CW'(iv_rd) < live_q) begin
						rmf_q   <= f_q;
						rmloc_q <= iv_rd;
						ret_q   <= S_DONE;
						st_q    <= S_REM_A;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_REM_A: begin
					live_q <= live_q - CW'(1);
					st_q   <= S_REM_B;
				end
				S_REM_B: st_q <= ret_q;
				S_CULL_NEXT: begin
					if (loc_q == '0) begin
						st_q <= S_SET_FULL;
					end else begin
						loc_q <= loc_q - CW'(1);
						st_q  <= S_CULL_AL;
					end
				end
				S_CULL_AL: begin
					wf_q <= al_rd;
					st_q <= S_CULL_TR;
				end
				S_CULL_TR: begin
					if (tr_rd < thr_q) begin
						rmf_q   <= wf_q;
						rmloc_q <= LW'(loc_q);
						ret_q   <= S_CULL_NEXT;
						st_q    <= S_REM_A;
					end else begin
						st_q <= S_CULL_NEXT;
					end
				end
				S_DEC_NEXT: begin
					if (loc_q == '0) begin
						st_q <= S_DONE;
					end else begin
						loc_q <= loc_q - CW'(1);
						st_q  <= S_DEC_AL;
					end
				end
				S_DEC_AL: begin
					wf_q <= al_rd;
					st_q <= S_DEC_TR;
				end
				S_DEC_TR: begin
					if (dec_nt == '0 || dec_nt < thr_q) begin
						rmf_q   <= wf_q;
						rmloc_q <= LW'(loc_q);
						ret_q   <= S_DEC_NEXT;
						st_q    <= S_REM_A;
					end else begin
						st_q <= S_DEC_NEXT;
					end
				end
				S_UPD_NEXT: st_q <= (loc_q < live_q) ? S_UPD_AL : S_DONE;
				S_UPD_AL: begin
					wf_q <= al_rd;
					st_q <= S_UPD_TR;
				end
				S_UPD_TR:  st_q <= S_UPD_MUL;
				S_UPD_MUL: st_q <= S_UPD_WR;
				S_UPD_WR: begin
					loc_q <= loc_q + CW'(1);
					st_q  <= S_UPD_NEXT;
				end
				S_ACC_RD: begin
					if (last_q) begin
						qsum_q <= asat;
						qv_q   <= 1'b1;
						acc_q  <= '0;
					end else begin
						acc_q <= asat;
					end
					st_q <= S_DONE;
				end
				S_SWEEP: begin
					sw_q <= sw_q + AW'(1);
					if (sw_q == AW'(TABLE_DEPTH - 1)) begin
						st_q <= swinit_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy                = (st_q != S_IDLE);
	assign done                = (st_q == S_DONE);
	assign result.q_sum        = qsum_q;
	assign result.q_valid      = qv_q;
	assign result.active_count = setsu_pkg::CNT_W'(live_q);
	assign result.min_trace    = thr_q;

endmodule

@@ rtl/setsu_incr.sv @@
// ----------------------------------------------------------------------------
// setsu_incr: weight increment pipeline
// Two registered stages: step_scale*trace, then delta times that product,
// rounded to the nearest step with halves toward plus infinity.
// ----------------------------------------------------------------------------
module setsu_incr (
	input  logic                clk,
	input  logic signed [31:0]  delta,
	input  logic [15:0]         scale,
	input  logic [15:0]         trace,
	output logic signed [32:0]  inc
);

	logic [31:0]        st_s1;
	logic signed [31:0] d_s1;
	logic signed [64:0] prod;
	logic signed [64:0] psum;
	logic signed [32:0] inc_s2;

	always_ff @(posedge clk) begin
		st_s1 <= 32'(scale) * 32'(trace);
		d_s1  <= delta;
	end

	// Floor of (p + 2^30) / 2^31 equals round-half-up of p / 2^31.
	always_comb begin
		prod = 65'(d_s1) * 65'(signed'({1'b0, st_s1}));
		psum = prod + 65'sd1073741824;
	end

	always_ff @(posedge clk) begin
		inc_s2 <= 33'(psum >>> 31);
	end

	assign inc = inc_s2;

endmodule
